/* rtl/skl_pkg.sv */
package skl_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [2:0] {
    ACT_ORD_INS   = 3'd0,
    ACT_FRONT_INS = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    front;
    logic                    del;
    logic                    rot;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] head;
  } cell_ctrl_t;

  // cell i -> cell i+1
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    occ;
    logic                    prior_ins;
    logic                    prior_del;
  } fwd_t;

  // cell i+1 -> cell i
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    occ;
  } bwd_t;

endpackage

/* rtl/skl_cell.sv */
module skl_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                clk_i,
  input  skl_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  skl_pkg::fwd_t       left_i,
  input  skl_pkg::bwd_t       right_i,
  output skl_pkg::fwd_t       right_o,
  output skl_pkg::bwd_t       left_o
);
  import skl_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic cond, sel_ins, match;

  always_comb begin
    if (IS_HEAD) begin
      cond = ctrl_i.front || !occ_i || (key_q > ctrl_i.key);
    end else begin
      cond = (!occ_i && left_i.occ) ||
             (occ_i && left_i.occ && (left_i.key < ctrl_i.key) && (ctrl_i.key <= key_q));
    end
    sel_ins = !left_i.prior_ins && cond;
    match   = occ_i && (key_q == ctrl_i.key);
  end

  assign right_o.key       = key_q;
  assign right_o.occ       = occ_i;
  assign right_o.prior_ins = left_i.prior_ins || sel_ins;
  assign right_o.prior_del = left_i.prior_del || match;
  assign left_o.key        = key_q;
  assign left_o.occ        = occ_i;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (left_i.prior_ins) begin
        key_d = left_i.key;
      end else if (sel_ins) begin
        key_d = ctrl_i.key;
      end
    end else if (ctrl_i.del) begin
      if (right_o.prior_del) begin
        key_d = right_i.key;
      end
    end else if (ctrl_i.rot) begin
      key_d = right_i.occ ? right_i.key : ctrl_i.head;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

/* rtl/sorted_key_list.sv */
// Insert, delete, clear and undefined actions give one registered result in the cycle after
// the transaction; busy_o stays low, so one transaction per cycle.
// Read out: busy_o is high while the cell row rotates once (one rotation per entry), and each
// rotation gives one registered entry result; an empty list gives one result like the others.
// Results cannot be stalled. Reset (async, active low) empties the list and clears control.
module sorted_key_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [2:0]                        action_i,
  input  logic signed [skl_pkg::KEY_W-1:0]  key_i,
  output logic                              strobe_o,
  output logic [1:0]                        status_o,
  output logic signed [skl_pkg::KEY_W-1:0]  entry_key_o,
  output logic                              entry_valid_o,
  output logic [skl_pkg::OCC_W-1:0]         occupancy_o,
  output logic                              last_o
);
  import skl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;

  logic                    strobe_q, strobe_d;
  status_e                 status_q, status_d;
  logic signed [KEY_W-1:0] ekey_q, ekey_d;
  logic                    evalid_q, evalid_d;
  logic [OCC_W-1:0]        occ_q, occ_d;
  logic                    last_q, last_d;

  cell_ctrl_t      ctrl;
  logic [CAPACITY-1:0] occ;
  fwd_t            fwd [CAPACITY+1];
  bwd_t            bwd [CAPACITY+1];

  logic    accept, full, found;
  action_e act;
  logic [CW+OCC_W-1:0] occ_ext;

  assign busy_o = (state_q == S_READ);
  assign accept = start_i && !busy_o;
  assign act    = action_e'(action_i);
  assign full   = (count_q == CW'(CAPACITY));
  assign found  = fwd[CAPACITY].prior_del;

  assign fwd[0]        = '0;
  assign bwd[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count_q > CW'(i));
    skl_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .occ_i   (occ[i]),
      .left_i  (fwd[i]),
      .right_i (bwd[i+1]),
      .right_o (fwd[i+1]),
      .left_o  (bwd[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (act == ACT_READ) && (count_q != '0)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (rd_q == CW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.key  = key_i;
    ctrl.head = bwd[0].key;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (act) inside
            ACT_ORD_INS, ACT_FRONT_INS: begin
              ctrl.ins   = !full;
              ctrl.front = (act == ACT_FRONT_INS);
            end
            ACT_DELETE: ctrl.del = 1'b1;
            default: ;
          endcase
        end
      end
      S_READ: ctrl.rot = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    rd_d       = rd_q;
    strobe_d   = 1'b0;
    status_d   = ST_DONE;
    ekey_d     = '0;
    evalid_d   = 1'b0;
    last_d     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          strobe_d = 1'b1;
          unique case (act) inside
            ACT_ORD_INS, ACT_FRONT_INS: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            ACT_DELETE: begin
              if (found) begin
                count_d = count_q - CW'(1);
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            ACT_CLEAR: count_d = '0;
            ACT_READ: begin
              if (count_q != '0) begin
                strobe_d = 1'b0;
                rd_d     = count_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        strobe_d = 1'b1;
        ekey_d   = bwd[0].key;
        evalid_d = 1'b1;
        last_d   = (rd_q == CW'(1));
        rd_d     = rd_q - CW'(1);
      end
      default: ;
    endcase
    occ_ext = {{OCC_W{1'b0}}, count_d};
    occ_d   = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_q     <= rd_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ekey_q   <= ekey_d;
    evalid_q <= evalid_d;
    occ_q    <= occ_d;
    last_q   <= last_d;
  end

  assign strobe_o      = strobe_q;
  assign status_o      = status_q;
  assign entry_key_o   = ekey_q;
  assign entry_valid_o = evalid_q;
  assign occupancy_o   = occ_q;
  assign last_o        = last_q;

endmodule

/* rtl/skl_chk.sv */
module skl_chk #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic [2:0]                        action_i,
  input logic signed [skl_pkg::KEY_W-1:0]  key_i,
  input logic                              strobe_o,
  input logic [1:0]                        status_o,
  input logic signed [skl_pkg::KEY_W-1:0]  entry_key_o,
  input logic                              entry_valid_o,
  input logic [skl_pkg::OCC_W-1:0]         occupancy_o,
  input logic                              last_o
);
  import skl_pkg::*;

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (action_i != ACT_READ) |=> strobe_o && last_o && !entry_valid_o)
    else $error("non-read transaction did not give one result");

  a_read_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> strobe_o && last_o && entry_valid_o)
    else $error("read out did not end with last entry");

  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !entry_valid_o |-> (entry_key_o == '0))
    else $error("non-entry result carries a key");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == ST_FULL) |-> (occupancy_o == OCC_W'(CAPACITY)))
    else $error("full status while list not full");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> strobe_o && entry_valid_o)
    else $error("read cycle without an entry result");

endmodule

bind sorted_key_list skl_chk #(.CAPACITY(CAPACITY)) u_skl_chk (.*);
